// File: rtl/core/crc_encoder_with_bit_flip_top_assert.svh
// Assertion macros used by the checker file.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef CRC_ENCODER_WITH_BIT_FLIP_TOP_ASSERT_SVH
`define CRC_ENCODER_WITH_BIT_FLIP_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CRCBF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CRCBF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/crcbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package crcbf_pkg;

	localparam int MAX_DEGREE_DEF = 32;
	localparam int INDEX_BITS_DEF = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int CRC_DEGREE_W = 6;
	localparam int TAPS_W = 32;
	localparam int FLIP_W = 16;

	localparam logic [CRC_DEGREE_W-1:0] RST_CRC_DEGREE = 6'd16;
	localparam logic [TAPS_W-1:0] RST_GENERATOR_TAPS = 32'h0000_1021;
	localparam logic [FLIP_W-1:0] RST_FLIP_POSITION = 16'd0;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_CRC_DEGREE = 2'd0,
		REG_GENERATOR_TAPS = 2'd1,
		REG_FLIP_POSITION = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic message_bit;
		logic message_last;
	} in_word_t;

	typedef struct packed {
		logic code_bit;
		logic is_check;
		logic code_last;
	} out_word_t;

endpackage
`default_nettype wire

// File: rtl/core/crcbf_front.sv
`timescale 1ns / 1ps
`default_nettype none
module crcbf_front #(
	parameter int MAX_DEGREE = crcbf_pkg::MAX_DEGREE_DEF,
	parameter int INDEX_BITS = crcbf_pkg::INDEX_BITS_DEF,
	parameter int DEG_W = $clog2(MAX_DEGREE + 1),
	parameter int ENTRY_W = MAX_DEGREE + DEG_W + 2
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input crcbf_pkg::in_word_t in_data,
	input wire logic cfg_wen,
	input wire logic [crcbf_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input wire logic [crcbf_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output logic push_valid,
	input wire logic push_ready,
	output logic [ENTRY_W-1:0] push_data
);
	import crcbf_pkg::*;

	localparam int IDX_W = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
	localparam int TAPS_EXT_W = (MAX_DEGREE > TAPS_W) ? MAX_DEGREE : TAPS_W;
	localparam int CMP_W = ((INDEX_BITS > FLIP_W) ? INDEX_BITS : FLIP_W) + 1;
	localparam logic [CRC_DEGREE_W:0] MAX_DEG_V = (CRC_DEGREE_W + 1)'(MAX_DEGREE);

	logic [CRC_DEGREE_W-1:0] crc_degree_q;
	logic [TAPS_W-1:0] taps_q;
	logic [FLIP_W-1:0] flip_q;
	logic [MAX_DEGREE-1:0] rem_q;
	logic [INDEX_BITS-1:0] bit_index_q;

	logic [DEG_W-1:0] deg;
	logic [DEG_W-1:0] deg_m1;
	logic [MAX_DEGREE-1:0] mask;
	logic [TAPS_EXT_W-1:0] taps_wide;
	logic [MAX_DEGREE-1:0] taps_ext;
	logic not_sat;
	logic do_flip;
	logic cur_bit;
	logic fb;
	logic [MAX_DEGREE-1:0] rem_next;
	logic accept;

	// clamp degree into 1..MAX_DEGREE
	always_comb begin
		if (crc_degree_q == '0) begin
			deg = DEG_W'(1);
		end else if ({1'b0, crc_degree_q} > MAX_DEG_V) begin
			deg = DEG_W'(MAX_DEGREE);
		end else begin
			deg = DEG_W'(crc_degree_q);
		end
	end

	assign deg_m1 = deg - DEG_W'(1);

	always_comb begin
		for (int i = 0; i < MAX_DEGREE; i++) begin
			mask[i] = (i < int'(deg));
		end
	end

	assign taps_wide = TAPS_EXT_W'(taps_q);
	assign taps_ext = taps_wide[MAX_DEGREE-1:0];

	assign not_sat = ~&bit_index_q;
	assign do_flip = not_sat && ((CMP_W'(bit_index_q) + CMP_W'(1)) == CMP_W'(flip_q));
	assign cur_bit = in_data.message_bit ^ do_flip;
	assign fb = cur_bit ^ rem_q[deg_m1[IDX_W-1:0]];
	assign rem_next = ((rem_q << 1) & mask) ^ ({MAX_DEGREE{fb}} & taps_ext & mask);

	assign accept = in_valid && push_ready;
	assign in_ready = push_ready;
	assign push_valid = in_valid;
	assign push_data = {cur_bit, in_data.message_last, deg, rem_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_degree_q <= RST_CRC_DEGREE;
			taps_q <= RST_GENERATOR_TAPS;
			flip_q <= RST_FLIP_POSITION;
		end else if (cfg_wen) begin
			case (cfg_addr)
				REG_CRC_DEGREE: crc_degree_q <= cfg_wdata[CRC_DEGREE_W-1:0];
				REG_GENERATOR_TAPS: taps_q <= cfg_wdata[TAPS_W-1:0];
				REG_FLIP_POSITION: flip_q <= cfg_wdata[FLIP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			bit_index_q <= '0;
		end else if (accept) begin
			// clear after the last bit; the remainder rides in the queue word
			if (in_data.message_last) begin
				rem_q <= '0;
				bit_index_q <= '0;
			end else begin
				rem_q <= rem_next;
				if (not_sat) begin
					bit_index_q <= bit_index_q + INDEX_BITS'(1);
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/crcbf_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module crcbf_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = crcbf_pkg::QUEUE_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push_valid,
	output logic push_ready,
	input wire logic [WIDTH-1:0] push_data,
	output logic pop_valid,
	input wire logic pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	import crcbf_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data = slot_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/crcbf_back.sv
`timescale 1ns / 1ps
`default_nettype none
module crcbf_back #(
	parameter int MAX_DEGREE = crcbf_pkg::MAX_DEGREE_DEF,
	parameter int DEG_W = $clog2(MAX_DEGREE + 1),
	parameter int ENTRY_W = MAX_DEGREE + DEG_W + 2
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic pop_valid,
	output logic pop_ready,
	input wire logic [ENTRY_W-1:0] pop_data,
	output logic out_valid,
	input wire logic out_ready,
	output crcbf_pkg::out_word_t out_data
);
	import crcbf_pkg::*;

	localparam int IDX_W = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

	logic [MAX_DEGREE-1:0] e_rem;
	logic [DEG_W-1:0] e_deg;
	logic e_last;
	logic e_bit;

	logic out_valid_q;
	out_word_t out_data_q;
	logic [MAX_DEGREE-1:0] shreg_q;
	logic [DEG_W-1:0] cnt_q;
	logic [DEG_W-1:0] cnt_m1;
	logic draining;
	logic adv;

	assign e_rem = pop_data[MAX_DEGREE-1:0];
	assign e_deg = pop_data[MAX_DEGREE +: DEG_W];
	assign e_last = pop_data[MAX_DEGREE + DEG_W];
	assign e_bit = pop_data[MAX_DEGREE + DEG_W + 1];

	assign draining = (cnt_q != '0);
	assign cnt_m1 = cnt_q - DEG_W'(1);
	// output register is free or being emptied this cycle
	assign adv = !out_valid_q || out_ready;
	assign pop_ready = adv && !draining;

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cnt_q <= '0;
		end else if (adv) begin
			if (draining) begin
				out_valid_q <= 1'b1;
				cnt_q <= cnt_m1;
			end else if (pop_valid) begin
				out_valid_q <= 1'b1;
				if (e_last) begin
					cnt_q <= e_deg;
				end
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (draining) begin
				// check bits leave most significant first
				out_data_q.code_bit <= shreg_q[cnt_m1[IDX_W-1:0]];
				out_data_q.is_check <= 1'b1;
				out_data_q.code_last <= (cnt_q == DEG_W'(1));
			end else if (pop_valid) begin
				out_data_q.code_bit <= e_bit;
				out_data_q.is_check <= 1'b0;
				out_data_q.code_last <= 1'b0;
				if (e_last) begin
					shreg_q <= e_rem;
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/crc_encoder_with_bit_flip_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Serial CRC encoder with one-bit error injection. Message bits enter one per cycle while
// in_ready is high, MSB first, with a last mark; the bit at the 1-based flip_position is
// inverted (0 or past the end: none), passed out as a message word and folded into a Galois
// remainder under the programmed generator (leading one implied). After a last bit the back
// end sends crc_degree (clamped to 1..MAX_DEGREE) check words, MSB first, the final one with
// code_last. The back end's single output register takes no queue word during that drain,
// and input stalls once the two-word queue fills. The user must write configuration through
// cfg_wen/cfg_addr/cfg_wdata only while the block is idle; the block does not enforce this.
module crc_encoder_with_bit_flip_top #(
	parameter int MAX_DEGREE = crcbf_pkg::MAX_DEGREE_DEF,
	parameter int INDEX_BITS = crcbf_pkg::INDEX_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input crcbf_pkg::in_word_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output crcbf_pkg::out_word_t out_data,
	input wire logic cfg_wen,
	input wire logic [crcbf_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input wire logic [crcbf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import crcbf_pkg::*;

	localparam int DEG_W = $clog2(MAX_DEGREE + 1);
	localparam int ENTRY_W = MAX_DEGREE + DEG_W + 2;

	logic push_valid;
	logic push_ready;
	logic [ENTRY_W-1:0] push_data;
	logic pop_valid;
	logic pop_ready;
	logic [ENTRY_W-1:0] pop_data;

	crcbf_front #(
		.MAX_DEGREE(MAX_DEGREE),
		.INDEX_BITS(INDEX_BITS),
		.DEG_W(DEG_W),
		.ENTRY_W(ENTRY_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.cfg_wen(cfg_wen),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data)
	);

	crcbf_queue #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data)
	);

	crcbf_back #(
		.MAX_DEGREE(MAX_DEGREE),
		.DEG_W(DEG_W),
		.ENTRY_W(ENTRY_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule
`default_nettype wire

// File: rtl/core/crcbf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "crc_encoder_with_bit_flip_top_assert.svh"
module crcbf_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input crcbf_pkg::out_word_t out_data
);
	import crcbf_pkg::*;

	// a stalled output word holds
	`CRCBF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output word changed while stalled")

	// only a check word may close the codeword
	`CRCBF_ASSERT_SAME(a_last_is_check, out_valid && out_data.code_last, out_data.is_check, "code_last on a message word")

	// check words drain back to back until the last one
	`CRCBF_ASSERT_NEXT(a_check_chain, out_valid && out_ready && out_data.is_check && !out_data.code_last, out_valid && out_data.is_check, "gap or message word inside the check bits")

	// after the final check word the next word, if valid, is a message bit
	`CRCBF_ASSERT_NEXT(a_after_last, out_valid && out_ready && out_data.code_last, !out_valid || !out_data.is_check, "check word after the end of a codeword")

endmodule

bind crc_encoder_with_bit_flip_top crcbf_checker u_crcbf_checker (.*);
`default_nettype wire
